// ===== rtl/fitk_pkg.sv =====
// Shared types and constants for the frequent item top-k block.
// Used by fitk_cell and frequent_item_top_k; depends on nothing else.
`default_nettype none

package fitk_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // Field widths fixed by the interface.
   localparam int ID_W    = 16;
   localparam int CNT_W   = 16;
   localparam int LEN_W   = 10;
   localparam int RANK_W  = 4;
   localparam int FILL_W  = 5;
   localparam int NUM_W   = 16;
   localparam int THR_W   = 10;
   localparam int SIZE_W  = 5;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Products of a count with 1000, and of a threshold with the structure
   // total, both fit in 26 bits.
   localparam int PROD_W    = 26;
   localparam int OCC_SCALE = 1000;

   // Reset values of the configuration registers.
   localparam logic [NUM_W-1:0]  NUM_STRUCTS_RST = 16'd1000;
   localparam logic [THR_W-1:0]  COMMON_THR_RST  = 10'd500;
   localparam logic [THR_W-1:0]  FREQ_THR_RST    = 10'd100;
   localparam logic [LEN_W-1:0]  MIN_LENGTH_RST  = 10'd0;
   localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 5'd10;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STRUCTS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMON_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_THR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SIZE = 3'd4;

   typedef enum logic [1:0] {
      KIND_OFFER = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CAT_SHORT   = 3'd0,
      CAT_COMMON  = 3'd1,
      CAT_KEPT    = 3'd2,
      CAT_DROPPED = 3'd3,
      CAT_RARE    = 3'd4
   } category_type;

   typedef struct packed {
      kind_type              kind;
      logic [ID_W-1:0]       item_id;
      logic [CNT_W-1:0]      occurrence;
      logic [LEN_W-1:0]      item_length;
      logic [RANK_W-1:0]     rank;
   } req_type;

   typedef struct packed {
      category_type          category;
      logic                  evicted_valid;
      logic [ID_W-1:0]       evicted_id;
      logic [CNT_W-1:0]      evicted_count;
      logic                  entry_valid;
      logic [ID_W-1:0]       entry_id;
      logic [CNT_W-1:0]      entry_count;
      logic [FILL_W-1:0]     fill_level;
   } rsp_type;

   // Broadcast to every cell of the list.
   typedef struct packed {
      logic                  ins;
      logic [ID_W-1:0]       id;
      logic [CNT_W-1:0]      count;
   } bcast_type;

   // What one cell hands to its right-hand neighbour.
   typedef struct packed {
      logic                  gt;
      logic [ID_W-1:0]       id;
      logic [CNT_W-1:0]      count;
   } link_type;

endpackage

`default_nettype wire

// ===== rtl/fitk_cell.sv =====
// One entry of the sorted list: holds an id and a count and shifts right on insert.
// Depends on fitk_pkg.
`default_nettype none

module fitk_cell (
   input  wire logic                 clock,
   input  wire fitk_pkg::bcast_type  bcast,
   input  wire logic                 live,
   input  wire logic                 upd,
   input  wire fitk_pkg::link_type   prev,
   output fitk_pkg::link_type        nxt
);

   logic [fitk_pkg::ID_W-1:0]  id_ff;
   logic [fitk_pkg::CNT_W-1:0] count_ff;
   logic [fitk_pkg::ID_W-1:0]  id_in;
   logic [fitk_pkg::CNT_W-1:0] count_in;
   logic                       gt;

   // A held entry stays ahead of the new item only when strictly greater.
   assign gt = live && (count_ff > bcast.count);

   always_comb begin
      id_in    = id_ff;
      count_in = count_ff;
      if (bcast.ins && upd && !gt) begin
         if (prev.gt) begin
            id_in    = bcast.id;
            count_in = bcast.count;
         end else begin
            id_in    = prev.id;
            count_in = prev.count;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      count_ff <= count_in;
   end

   assign nxt.gt    = gt;
   assign nxt.id    = id_ff;
   assign nxt.count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/frequent_item_top_k.sv =====
// Frequent item classifier with a top-k list held in a row of fitk_cell entries.
// Latency: a word's result is registered at the edge that accepts it and shown the next cycle.
// Throughput: one word per cycle while rsp_stall is low; the row of cells compares and shifts
// a whole insert at once. The input side stalls only while the result side does.
// Reset (synchronous) restores the configuration defaults and empties the list;
// the stored entries themselves are not cleared, so there is no clearing pass.
`default_nettype none

module frequent_item_top_k #(
   parameter int DEPTH = fitk_pkg::DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire fitk_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output fitk_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [fitk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fitk_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int FW = fitk_pkg::FILL_W;
   localparam int CW = ($clog2(DEPTH + 1) > FW) ? $clog2(DEPTH + 1) : FW;

   function automatic logic [FW-1:0] clamp_cap(input logic [fitk_pkg::SIZE_W-1:0] size);
      logic [FW-1:0] c;
      c = FW'(size);
      if (size == '0) c = FW'(1);
      if (int'(size) > DEPTH) c = FW'(DEPTH);
      return c;
   endfunction

   // Configuration.
   logic [fitk_pkg::NUM_W-1:0]  num_structs_ff;
   logic [fitk_pkg::THR_W-1:0]  common_thr_ff;
   logic [fitk_pkg::THR_W-1:0]  freq_thr_ff;
   logic [fitk_pkg::LEN_W-1:0]  min_length_ff;
   logic [FW-1:0]               cap_ff;
   logic [fitk_pkg::PROD_W-1:0] common_lim_ff;
   logic [fitk_pkg::PROD_W-1:0] freq_lim_ff;
   logic [fitk_pkg::PROD_W-1:0] common_lim_in;
   logic [fitk_pkg::PROD_W-1:0] freq_lim_in;
   logic [FW-1:0]               cap_new;

   // List control and result register.
   logic [FW-1:0]               filled_ff;
   logic [FW-1:0]               filled_in;
   logic [FW-1:0]               n_ins;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   fitk_pkg::rsp_type           rsp_data_ff;
   fitk_pkg::rsp_type           rsp_in;
   logic                        req_accept;

   fitk_pkg::bcast_type         bcast;
   fitk_pkg::link_type          links [DEPTH];
   logic [DEPTH-1:0]            live;
   logic [DEPTH-1:0]            upd;

   logic [fitk_pkg::PROD_W-1:0] lhs;
   logic                        full;
   logic [fitk_pkg::ID_W-1:0]   last_id;
   logic [fitk_pkg::CNT_W-1:0]  last_count;
   logic [fitk_pkg::ID_W-1:0]   sel_id;
   logic [fitk_pkg::CNT_W-1:0]  sel_count;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // The threshold limits are kept as products, refreshed when either factor is written.
   assign cap_new = clamp_cap(csr_wdata[fitk_pkg::SIZE_W-1:0]);

   always_comb begin
      common_lim_in = common_lim_ff;
      freq_lim_in   = freq_lim_ff;
      if (csr_we) begin
         case (csr_index)
            fitk_pkg::CSR_NUM_STRUCTS: begin
               common_lim_in = fitk_pkg::PROD_W'(common_thr_ff)
                             * fitk_pkg::PROD_W'(csr_wdata[fitk_pkg::NUM_W-1:0]);
               freq_lim_in   = fitk_pkg::PROD_W'(freq_thr_ff)
                             * fitk_pkg::PROD_W'(csr_wdata[fitk_pkg::NUM_W-1:0]);
            end
            fitk_pkg::CSR_COMMON_THR: begin
               common_lim_in = fitk_pkg::PROD_W'(csr_wdata[fitk_pkg::THR_W-1:0])
                             * fitk_pkg::PROD_W'(num_structs_ff);
            end
            fitk_pkg::CSR_FREQ_THR: begin
               freq_lim_in = fitk_pkg::PROD_W'(csr_wdata[fitk_pkg::THR_W-1:0])
                           * fitk_pkg::PROD_W'(num_structs_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_structs_ff <= fitk_pkg::NUM_STRUCTS_RST;
         common_thr_ff  <= fitk_pkg::COMMON_THR_RST;
         freq_thr_ff    <= fitk_pkg::FREQ_THR_RST;
         min_length_ff  <= fitk_pkg::MIN_LENGTH_RST;
         cap_ff         <= clamp_cap(fitk_pkg::ACTIVE_SIZE_RST);
         common_lim_ff  <= fitk_pkg::PROD_W'(fitk_pkg::COMMON_THR_RST)
                         * fitk_pkg::PROD_W'(fitk_pkg::NUM_STRUCTS_RST);
         freq_lim_ff    <= fitk_pkg::PROD_W'(fitk_pkg::FREQ_THR_RST)
                         * fitk_pkg::PROD_W'(fitk_pkg::NUM_STRUCTS_RST);
      end else begin
         common_lim_ff <= common_lim_in;
         freq_lim_ff   <= freq_lim_in;
         if (csr_we) begin
            case (csr_index)
               fitk_pkg::CSR_NUM_STRUCTS: num_structs_ff <= csr_wdata[fitk_pkg::NUM_W-1:0];
               fitk_pkg::CSR_COMMON_THR:  common_thr_ff  <= csr_wdata[fitk_pkg::THR_W-1:0];
               fitk_pkg::CSR_FREQ_THR:    freq_thr_ff    <= csr_wdata[fitk_pkg::THR_W-1:0];
               fitk_pkg::CSR_MIN_LENGTH:  min_length_ff  <= csr_wdata[fitk_pkg::LEN_W-1:0];
               fitk_pkg::CSR_ACTIVE_SIZE: cap_ff         <= cap_new;
               default: ;
            endcase
         end
      end
   end

   // Entries at the rank asked for, and at the last place of the capacity.
   always_comb begin
      sel_id     = '0;
      sel_count  = '0;
      last_id    = '0;
      last_count = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CW'(i) == CW'(req_data.rank)) begin
            sel_id    = links[i].id;
            sel_count = links[i].count;
         end
         if (CW'(i) == CW'(cap_ff) - CW'(1)) begin
            last_id    = links[i].id;
            last_count = links[i].count;
         end
      end
   end

   assign lhs   = fitk_pkg::PROD_W'(req_data.occurrence) * fitk_pkg::PROD_W'(fitk_pkg::OCC_SCALE);
   assign full  = filled_ff >= cap_ff;
   // With a full list the last entry is evicted, so the insert sees one entry fewer.
   assign n_ins = full ? cap_ff - FW'(1) : filled_ff;

   always_comb begin
      bcast.ins    = 1'b0;
      bcast.id     = req_data.item_id;
      bcast.count  = req_data.occurrence;
      rsp_in       = '0;
      filled_in    = filled_ff;
      if (req_accept) begin
         case (req_data.kind)
            fitk_pkg::KIND_OFFER: begin
               if (min_length_ff != '0 && req_data.item_length < min_length_ff) begin
                  rsp_in.category = fitk_pkg::CAT_SHORT;
               end else if (lhs >= common_lim_ff) begin
                  rsp_in.category = fitk_pkg::CAT_COMMON;
               end else if (lhs >= freq_lim_ff) begin
                  if (full && req_data.occurrence <= last_count) begin
                     rsp_in.category = fitk_pkg::CAT_DROPPED;
                  end else begin
                     rsp_in.category = fitk_pkg::CAT_KEPT;
                     bcast.ins       = 1'b1;
                     filled_in       = n_ins + FW'(1);
                     if (full) begin
                        rsp_in.evicted_valid = 1'b1;
                        rsp_in.evicted_id    = last_id;
                        rsp_in.evicted_count = last_count;
                     end
                  end
               end else begin
                  rsp_in.category = fitk_pkg::CAT_RARE;
               end
            end
            fitk_pkg::KIND_READ: begin
               if (FW'(req_data.rank) < filled_ff) begin
                  rsp_in.entry_valid = 1'b1;
                  rsp_in.entry_id    = sel_id;
                  rsp_in.entry_count = sel_count;
               end
            end
            fitk_pkg::KIND_CLEAR: begin
               filled_in = '0;
            end
            default: ;
         endcase
         rsp_in.fill_level = filled_in;
      end
      // Lowering the capacity drops the lowest ranked entries.
      if (csr_we && csr_index == fitk_pkg::CSR_ACTIVE_SIZE && filled_in > cap_new) begin
         filled_in = cap_new;
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Row of cells; cell zero sees an always-greater left neighbour.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      fitk_pkg::link_type prev;

      assign live[g] = CW'(g) < CW'(filled_ff);
      assign upd[g]  = CW'(g) <= CW'(n_ins);

      if (g == 0) begin : g_head
         assign prev = '{gt: 1'b1, id: '0, count: '0};
      end else begin : g_body
         assign prev = links[g-1];
      end

      fitk_cell u_cell (
         .clock (clock),
         .bcast (bcast),
         .live  (live[g]),
         .upd   (upd[g]),
         .prev  (prev),
         .nxt   (links[g])
      );
   end

   // The fill count never runs past the capacity in use.
   a_fill_in_cap : assert property (@(posedge clock) disable iff (reset)
      filled_ff <= cap_ff)
      else $error("fill count above capacity");

   // Held entries stay in descending order of count.
   for (genvar g = 0; g < DEPTH - 1; g++) begin : g_order
      a_sorted : assert property (@(posedge clock) disable iff (reset)
         (CW'(g + 1) < CW'(filled_ff)) |-> (links[g].count >= links[g+1].count))
         else $error("list out of order");
   end

   // An offer without a configuration write beside it never shrinks the list.
   a_offer_grows : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.kind == fitk_pkg::KIND_OFFER && !csr_we)
         |=> (filled_ff >= $past(filled_ff)))
      else $error("offer shrank the list");

   // A clear shows an empty list in its result word.
   a_clear_empty : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.kind == fitk_pkg::KIND_CLEAR)
         |=> (rsp_valid_ff && rsp_data_ff.fill_level == '0))
      else $error("clear left entries");

   // An eviction only comes with a kept frequent item.
   a_evict_kept : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.evicted_valid)
         |-> (rsp_data_ff.category == fitk_pkg::CAT_KEPT))
      else $error("eviction without insert");

endmodule

`default_nettype wire

// ===== dv/tb_frequent_item_top_k.sv =====
// Self-checking testbench for frequent_item_top_k: classification of offers and the ranked list.
// Keeps its own copy of the list and registers to work out each result word.
// Depends on fitk_pkg and the frequent_item_top_k RTL only.
module tb_frequent_item_top_k;
   import fitk_pkg::*;

   localparam int TOP_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // Shadow registers and list contents.
   longint unsigned reg_num_structs;
   longint unsigned reg_common_thr;
   longint unsigned reg_freq_thr;
   longint unsigned reg_min_length;
   longint unsigned reg_active_size;
   logic [ID_W-1:0] top_ids [TOP_DEPTH];
   logic [CNT_W-1:0] top_counts [TOP_DEPTH];
   int unsigned top_fill;

   rsp_type due_outcomes [$];
   rsp_type head_outcome;
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit idling = 1'b1;
   bit quiet = 1'b0;

   frequent_item_top_k #(.DEPTH(TOP_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // An active size of zero behaves as one, and anything above the depth as the depth.
   function automatic int unsigned list_capacity();
      int unsigned c;
      c = reg_active_size;
      if (c < 1) c = 1;
      if (c > TOP_DEPTH) c = TOP_DEPTH;
      return c;
   endfunction

   function automatic rsp_type track_top_k(input req_type w);
      rsp_type r;
      longint unsigned scaled;
      int unsigned cap;
      int unsigned n;
      int unsigned pos;
      r = '0;
      case (w.kind)
         KIND_OFFER: begin
            scaled = longint'(w.occurrence) * OCC_SCALE;
            if (reg_min_length != 0 && w.item_length < reg_min_length) begin
               r.category = CAT_SHORT;
            end else if (scaled >= reg_common_thr * reg_num_structs) begin
               r.category = CAT_COMMON;
            end else if (scaled >= reg_freq_thr * reg_num_structs) begin
               cap = list_capacity();
               n = (top_fill > cap) ? cap : top_fill;
               if (n >= cap && w.occurrence <= top_counts[cap-1]) begin
                  r.category = CAT_DROPPED;
               end else begin
                  if (n >= cap) begin
                     r.evicted_valid = 1'b1;
                     r.evicted_id = top_ids[cap-1];
                     r.evicted_count = top_counts[cap-1];
                     n = cap - 1;
                  end
                  // Equal counts do not stay ahead: the newcomer goes in front of them.
                  pos = 0;
                  while (pos < n && top_counts[pos] > w.occurrence) pos++;
                  for (int i = n; i > pos; i--) begin
                     top_ids[i] = top_ids[i-1];
                     top_counts[i] = top_counts[i-1];
                  end
                  top_ids[pos] = w.item_id;
                  top_counts[pos] = w.occurrence;
                  top_fill = n + 1;
                  r.category = CAT_KEPT;
               end
            end else begin
               r.category = CAT_RARE;
            end
         end
         KIND_READ: begin
            if (w.rank < top_fill) begin
               r.entry_valid = 1'b1;
               r.entry_id = top_ids[w.rank];
               r.entry_count = top_counts[w.rank];
            end
         end
         KIND_CLEAR: top_fill = 0;
         default: ;
      endcase
      r.fill_level = top_fill;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h", field, want, got);
      end
   endtask

   // Result side: random stall bursts and the comparison of each accepted word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result word arrived with nothing pending: %h", rsp_data);
         end else begin
            head_outcome = due_outcomes.pop_front();
            compare_field("category", head_outcome.category, rsp_data.category);
            compare_field("evicted_valid", head_outcome.evicted_valid, rsp_data.evicted_valid);
            compare_field("evicted_id", head_outcome.evicted_id, rsp_data.evicted_id);
            compare_field("evicted_count", head_outcome.evicted_count, rsp_data.evicted_count);
            compare_field("entry_valid", head_outcome.entry_valid, rsp_data.entry_valid);
            compare_field("entry_id", head_outcome.entry_id, rsp_data.entry_id);
            compare_field("entry_count", head_outcome.entry_count, rsp_data.entry_count);
            compare_field("fill_level", head_outcome.fill_level, rsp_data.fill_level);
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling && !quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Valid is left high after acceptance; back-to-back words lower it only for a random idle gap.
   task automatic send_word(input req_type w);
      if (idling && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      due_outcomes.push_back(track_top_k(w));
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_outcomes.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_NUM_STRUCTS: reg_num_structs = value[NUM_W-1:0];
         CSR_COMMON_THR:  reg_common_thr = value[THR_W-1:0];
         CSR_FREQ_THR:    reg_freq_thr = value[THR_W-1:0];
         CSR_MIN_LENGTH:  reg_min_length = value[LEN_W-1:0];
         CSR_ACTIVE_SIZE: begin
            reg_active_size = value[SIZE_W-1:0];
            if (top_fill > list_capacity()) top_fill = list_capacity();
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type make_word(input kind_type k, input int unsigned id,
                                         input int unsigned occ, input int unsigned len,
                                         input int unsigned rnk);
      req_type w;
      w.kind = k;
      w.item_id = id[ID_W-1:0];
      w.occurrence = occ[CNT_W-1:0];
      w.item_length = len[LEN_W-1:0];
      w.rank = rnk[RANK_W-1:0];
      return w;
   endfunction

   // Offers lean towards the frequent band so the list fills, evicts and sees ties.
   function automatic req_type random_word();
      req_type w;
      longint unsigned lo;
      longint unsigned hi;
      int unsigned dice;
      w.item_id = $urandom_range(0, 65535);
      w.occurrence = $urandom_range(0, 65535);
      w.item_length = $urandom_range(0, 1023);
      w.rank = $urandom_range(0, 15);
      dice = $urandom_range(0, 99);
      if (dice < 80) w.kind = KIND_OFFER;
      else if (dice < 98) w.kind = KIND_READ;
      else if (dice == 98) w.kind = KIND_CLEAR;
      else w.kind = kind_type'(KIND_UNUSED);
      if (w.kind == KIND_OFFER) begin
         lo = (reg_freq_thr * reg_num_structs + OCC_SCALE - 1) / OCC_SCALE;
         hi = (reg_common_thr * reg_num_structs + OCC_SCALE - 1) / OCC_SCALE;
         if (hi > 65536) hi = 65536;
         dice = $urandom_range(0, 99);
         if (lo < hi && dice < 75) begin
            if (dice < 25 && hi - lo > 8) hi = lo + 8;
            w.occurrence = $urandom_range(int'(lo), int'(hi - 1));
         end
         if (reg_min_length != 0 && $urandom_range(0, 3) != 0)
            w.item_length = $urandom_range(int'(reg_min_length), 1023);
      end
      return w;
   endfunction

   // Reset settings: common from 500, frequent from 100 up to 499, capacity ten.
   task automatic test_directed_ranking();
      int unsigned fill_counts [8];
      fill_counts = '{200, 300, 300, 150, 499, 250, 120, 400};
      send_word(make_word(KIND_READ, 0, 0, 0, 0));
      send_word(make_word(KIND_OFFER, 16'h0000, 0, 0, 0));
      send_word(make_word(KIND_OFFER, 16'hFFFF, 16'hFFFF, 10'h3FF, 4'hF));
      send_word(make_word(KIND_OFFER, 16'h0010, 500, 5, 0));
      send_word(make_word(KIND_OFFER, 16'h0011, 499, 5, 0));
      send_word(make_word(KIND_OFFER, 16'h0012, 100, 5, 0));
      send_word(make_word(KIND_OFFER, 16'h0013, 99, 5, 0));
      for (int i = 0; i < 8; i++)
         send_word(make_word(KIND_OFFER, 16'h0100 + i, fill_counts[i], 7, 0));
      // The list is full: a count equal to the last entry is dropped, a larger one evicts it.
      send_word(make_word(KIND_OFFER, 16'h0200, 100, 9, 0));
      send_word(make_word(KIND_OFFER, 16'h0201, 300, 9, 0));
      send_word(make_word(KIND_READ, 0, 0, 0, 0));
      send_word(make_word(KIND_READ, 0, 0, 0, 15));
      send_word(make_word(KIND_READ, 0, 0, 0, 9));
      send_word(make_word(kind_type'(KIND_UNUSED), 16'h1234, 200, 3, 2));
      send_word(make_word(KIND_CLEAR, 0, 0, 0, 0));
      send_word(make_word(KIND_READ, 0, 0, 0, 0));
   endtask

   task automatic test_register_corners();
      wait_all_answered();
      set_register(CSR_MIN_LENGTH, 1023);
      send_word(make_word(KIND_OFFER, 16'h0300, 300, 1022, 0));
      send_word(make_word(KIND_OFFER, 16'h0301, 0, 1023, 0));
      wait_all_answered();
      // A structure total of zero makes every offer that is long enough common.
      set_register(CSR_MIN_LENGTH, 0);
      set_register(CSR_NUM_STRUCTS, 0);
      send_word(make_word(KIND_OFFER, 16'h0302, 0, 0, 0));
      wait_all_answered();
      set_register(CSR_NUM_STRUCTS, 65535);
      set_register(CSR_COMMON_THR, 1000);
      set_register(CSR_FREQ_THR, 0);
      send_word(make_word(KIND_OFFER, 16'h0303, 65535, 0, 0));
      send_word(make_word(KIND_OFFER, 16'h0304, 0, 0, 0));
      wait_all_answered();
      set_register(CSR_ACTIVE_SIZE, 0);
      send_word(make_word(KIND_OFFER, 16'h0305, 5, 0, 0));
      send_word(make_word(KIND_OFFER, 16'h0306, 5, 0, 0));
      wait_all_answered();
      set_register(CSR_ACTIVE_SIZE, 31);
      for (int i = 1; i <= 3; i++)
         send_word(make_word(KIND_OFFER, 16'h0310 + i, i, 0, 0));
      wait_all_answered();
      // Shrinking the capacity below the fill discards the lowest ranked entries.
      set_register(CSR_ACTIVE_SIZE, 2);
      send_word(make_word(KIND_READ, 0, 0, 0, 1));
      send_word(make_word(KIND_READ, 0, 0, 0, 2));
   endtask

   task automatic test_random_phases();
      int unsigned pick;
      int unsigned common_t;
      for (int phase = 0; phase < 6; phase++) begin
         wait_all_answered();
         pick = $urandom_range(0, 9);
         if (pick == 0) set_register(CSR_NUM_STRUCTS, 0);
         else if (pick == 1) set_register(CSR_NUM_STRUCTS, 1);
         else if (pick == 2) set_register(CSR_NUM_STRUCTS, 65535);
         else set_register(CSR_NUM_STRUCTS, $urandom_range(1, 65535));
         common_t = $urandom_range(0, 1000);
         set_register(CSR_COMMON_THR, common_t);
         if ($urandom_range(0, 4) == 0) set_register(CSR_FREQ_THR, $urandom_range(0, 1000));
         else set_register(CSR_FREQ_THR, $urandom_range(0, common_t));
         if ($urandom_range(0, 4) < 3) set_register(CSR_MIN_LENGTH, 0);
         else set_register(CSR_MIN_LENGTH, $urandom_range(0, 1023));
         pick = $urandom_range(0, 9);
         if (pick == 0) set_register(CSR_ACTIVE_SIZE, 1);
         else if (pick == 1) set_register(CSR_ACTIVE_SIZE, 16);
         else if (pick == 2) set_register(CSR_ACTIVE_SIZE, 0);
         else if (pick == 3) set_register(CSR_ACTIVE_SIZE, $urandom_range(17, 31));
         else set_register(CSR_ACTIVE_SIZE, $urandom_range(1, 16));
         idling = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 150; i++) begin
            // Hold the sender back mid-phase until every word has been answered.
            if (i == 75) wait_all_answered();
            send_word(random_word());
         end
      end
   endtask

   task automatic test_quiet_stream();
      wait_all_answered();
      quiet = 1'b1;
      for (int i = 0; i < 120; i++)
         send_word(random_word());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      reg_num_structs = NUM_STRUCTS_RST;
      reg_common_thr = COMMON_THR_RST;
      reg_freq_thr = FREQ_THR_RST;
      reg_min_length = MIN_LENGTH_RST;
      reg_active_size = ACTIVE_SIZE_RST;
      top_fill = 0;
      for (int i = 0; i < TOP_DEPTH; i++) begin
         top_ids[i] = '0;
         top_counts[i] = '0;
      end
      test_directed_ranking();
      test_register_corners();
      test_random_phases();
      test_quiet_stream();
      wait_all_answered();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
